[rtl/normal_map_merge_pixel_assert.svh]
// ----------------------------------------------------------------------------
// normal map merge assertion macros
// Concurrent assertion wrappers, empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef NORMAL_MAP_MERGE_PIXEL_ASSERT_SVH
`define NORMAL_MAP_MERGE_PIXEL_ASSERT_SVH
`ifndef SYNTHESIS
// property checked at every rising clock edge outside reset
`define NMM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("nmm: concurrent assertion failed");
// condition in one cycle implies expression in the next
`define NMM_ASSERT_NEXT(lbl, clk, rstn, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
    else $error("nmm: next-cycle assertion failed");
`else
`define NMM_ASSERT(lbl, clk, rstn, prop)
`define NMM_ASSERT_NEXT(lbl, clk, rstn, cond, expr)
`endif
`endif

[rtl/nmm_pkg.sv]
// ----------------------------------------------------------------------------
// nmm_pkg
// Shared constants of the normal map merge pipeline.
// ----------------------------------------------------------------------------
package nmm_pkg;

  // fixed-point fraction bits of unit components
  localparam int unsigned FRACTION_BITS = 15;

  // width of one color channel
  localparam int unsigned BYTE_W = 8;

  // byte code of the value zero
  localparam logic [BYTE_W-1:0] BYTE_MID = 8'd128;

  // alpha codes
  localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [BYTE_W-1:0] ALPHA_EMPTY  = 8'h00;

  // saturated color code
  localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hFF;

endpackage

[rtl/nmm_if.sv]
// ----------------------------------------------------------------------------
// nmm pixel channels
// Valid/ready channels for pixel pair words and merged pixel words.
// ----------------------------------------------------------------------------
interface nmm_in_if;
  logic                        valid;
  logic                        ready;
  logic [nmm_pkg::BYTE_W-1:0]  side_red;
  logic [nmm_pkg::BYTE_W-1:0]  side_green;
  logic [nmm_pkg::BYTE_W-1:0]  side_alpha;
  logic [nmm_pkg::BYTE_W-1:0]  top_green;
  logic [nmm_pkg::BYTE_W-1:0]  top_blue;

  modport source (
    output valid, side_red, side_green, side_alpha, top_green, top_blue,
    input  ready
  );
  modport sink (
    input  valid, side_red, side_green, side_alpha, top_green, top_blue,
    output ready
  );
endinterface

interface nmm_out_if;
  logic                        valid;
  logic                        ready;
  logic [nmm_pkg::BYTE_W-1:0]  out_red;
  logic [nmm_pkg::BYTE_W-1:0]  out_green;
  logic [nmm_pkg::BYTE_W-1:0]  out_blue;
  logic [nmm_pkg::BYTE_W-1:0]  out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

[rtl/nmm_isqrt.sv]
// ----------------------------------------------------------------------------
// nmm_isqrt
// Pipelined digit-by-digit integer square root, one root bit per stage,
// several lanes sharing valid and a sideband tag.
// ----------------------------------------------------------------------------
module nmm_isqrt #(
  parameter int unsigned LANES = 2,
  parameter int unsigned RW    = 23,
  parameter int unsigned TW    = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [2*RW-1:0]   rad_i  [LANES],
  input  logic [TW-1:0]     tag_i,
  output logic              valid_o,
  output logic [RW-1:0]     root_o [LANES],
  output logic [TW-1:0]     tag_o
);

  logic [2*RW-1:0] rad_q  [RW][LANES];
  logic [2*RW-1:0] rad_d  [RW][LANES];
  logic [RW:0]     rem_q  [RW][LANES];
  logic [RW:0]     rem_d  [RW][LANES];
  logic [RW-1:0]   root_q [RW][LANES];
  logic [RW-1:0]   root_d [RW][LANES];
  logic [TW-1:0]   tag_q  [RW];
  logic [RW-1:0]   vld_q;

  // one trial subtraction per stage and lane
  always_comb begin
    logic [2*RW-1:0] rad_p;
    logic [RW:0]     rem_p;
    logic [RW-1:0]   root_p;
    logic [RW+3:0]   cur;
    logic [RW+3:0]   trial;
    logic [RW+3:0]   diff;
    for (int s = 0; s < RW; s++) begin
      for (int l = 0; l < LANES; l++) begin
        if (s == 0) begin
          rad_p  = rad_i[l];
          rem_p  = '0;
          root_p = '0;
        end else begin
          rad_p  = rad_q[s-1][l];
          rem_p  = rem_q[s-1][l];
          root_p = root_q[s-1][l];
        end
        cur   = {1'b0, rem_p, rad_p[2*RW-1-2*s -: 2]};
        trial = {2'b00, root_p, 2'b01};
        diff  = cur - trial;
        rad_d[s][l] = rad_p;
        if (!diff[RW+3]) begin
          rem_d[s][l]  = diff[RW:0];
          root_d[s][l] = {root_p[RW-2:0], 1'b1};
        end else begin
          rem_d[s][l]  = cur[RW:0];
          root_d[s][l] = {root_p[RW-2:0], 1'b0};
        end
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[RW-2:0], valid_i};
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q    <= rad_d;
      rem_q    <= rem_d;
      root_q   <= root_d;
      tag_q[0] <= tag_i;
      for (int s = 1; s < RW; s++) begin
        tag_q[s] <= tag_q[s-1];
      end
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign tag_o   = tag_q[RW-1];

endmodule

[rtl/nmm_div.sv]
// ----------------------------------------------------------------------------
// nmm_div
// Pipelined restoring divider, one quotient bit per stage. The starting
// remainder must be below the divisor; zeros are shifted in below it.
// ----------------------------------------------------------------------------
module nmm_div #(
  parameter int unsigned LANES = 4,
  parameter int unsigned DW    = 23,
  parameter int unsigned QW    = 16,
  parameter int unsigned TW    = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [DW-1:0]     rem_i  [LANES],
  input  logic [DW-1:0]     div_i  [LANES],
  input  logic [TW-1:0]     tag_i,
  output logic              valid_o,
  output logic [QW-1:0]     quo_o  [LANES],
  output logic [TW-1:0]     tag_o
);

  logic [DW-1:0] rem_q [QW][LANES];
  logic [DW-1:0] rem_d [QW][LANES];
  logic [DW-1:0] div_q [QW][LANES];
  logic [DW-1:0] div_d [QW][LANES];
  logic [QW-1:0] quo_q [QW][LANES];
  logic [QW-1:0] quo_d [QW][LANES];
  logic [TW-1:0] tag_q [QW];
  logic [QW-1:0] vld_q;

  // one compare and subtract per stage and lane
  always_comb begin
    logic [DW-1:0] rem_p;
    logic [DW-1:0] div_p;
    logic [QW-1:0] quo_p;
    logic [DW+1:0] cur;
    logic [DW+1:0] diff;
    for (int s = 0; s < QW; s++) begin
      for (int l = 0; l < LANES; l++) begin
        if (s == 0) begin
          rem_p = rem_i[l];
          div_p = div_i[l];
          quo_p = '0;
        end else begin
          rem_p = rem_q[s-1][l];
          div_p = div_q[s-1][l];
          quo_p = quo_q[s-1][l];
        end
        cur  = {1'b0, rem_p, 1'b0};
        diff = cur - {2'b00, div_p};
        div_d[s][l] = div_p;
        if (!diff[DW+1]) begin
          rem_d[s][l] = diff[DW-1:0];
          quo_d[s][l] = {quo_p[QW-2:0], 1'b1};
        end else begin
          rem_d[s][l] = cur[DW-1:0];
          quo_d[s][l] = {quo_p[QW-2:0], 1'b0};
        end
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QW-2:0], valid_i};
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q    <= rem_d;
      div_q    <= div_d;
      quo_q    <= quo_d;
      tag_q[0] <= tag_i;
      for (int s = 1; s < QW; s++) begin
        tag_q[s] <= tag_q[s-1];
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign tag_o   = tag_q[QW-1];

endmodule

[rtl/normal_map_merge_pixel.sv]
// ----------------------------------------------------------------------------
// normal_map_merge_pixel
// Merges a side and a top normal map pixel into one normalized direction.
// ----------------------------------------------------------------------------
//  channel     dir  word
//  pix_in_i    in   side red/green/alpha, top green/blue
//  pix_out_o   out  merged red/green/blue/alpha
//
//  One word per cycle while the output is not stalled. The path runs
//  through the two square root pipelines (one root bit per stage) and the
//  two divider pipelines (one quotient bit per stage).
//  Reset clears only the valid bits. A stalled output holds every stage and
//  the input in place; nothing moves until the waiting word leaves.
// ----------------------------------------------------------------------------
`include "normal_map_merge_pixel_assert.svh"

module normal_map_merge_pixel #(
  parameter int unsigned FRACTION_BITS = nmm_pkg::FRACTION_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  nmm_in_if.sink      pix_in_i,
  nmm_out_if.source   pix_out_o
);

  localparam int unsigned F    = FRACTION_BITS;
  localparam int unsigned QW   = F + 1;
  localparam int unsigned R2W  = F + 8;
  localparam int unsigned R3W  = F + 7;
  localparam int unsigned SQW  = 2 * QW;
  localparam int unsigned TW2  = 39;
  localparam int unsigned TWD2 = 7;
  localparam int unsigned TW3  = 5 + 3 * QW;
  localparam int unsigned TWD3 = 5;
  localparam logic [QW-1:0]  ONE_Q = {1'b1, {F{1'b0}}};
  localparam logic [F+1:0]   ONE_T = {2'b01, {F{1'b0}}};

  logic en;

  // stage A: byte decode to sign and magnitude
  logic [7:0] a_mag_q [4];
  logic [3:0] a_neg_q;
  logic       a_empty_q;
  logic       a_vld_q;
  logic [7:0] in_byte [4];
  logic [7:0] a_mag_d [4];
  logic [3:0] a_neg_d;

  assign in_byte[0] = pix_in_i.side_red;
  assign in_byte[1] = pix_in_i.side_green;
  assign in_byte[2] = pix_in_i.top_green;
  assign in_byte[3] = pix_in_i.top_blue;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      a_neg_d[i] = ~in_byte[i][7];
      a_mag_d[i] = in_byte[i][7] ? {1'b0, in_byte[i][6:0]}
                                 : nmm_pkg::BYTE_MID - in_byte[i];
    end
  end

  // stage B: squared lengths of both pairs
  logic [15:0] b_s_q [2];
  logic [1:0]  b_zero_q;
  logic [7:0]  b_mag_q [4];
  logic [3:0]  b_neg_q;
  logic        b_empty_q;
  logic        b_vld_q;
  logic [15:0] sq2 [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sq2[i] = {8'd0, a_mag_q[i]} * {8'd0, a_mag_q[i]};
    end
  end

  // stage register A and B
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= pix_in_i.valid;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_mag_q   <= a_mag_d;
      a_neg_q   <= a_neg_d;
      a_empty_q <= (pix_in_i.side_alpha == 8'd0);
      b_s_q[0]  <= sq2[0] + sq2[1];
      b_s_q[1]  <= sq2[2] + sq2[3];
      b_zero_q  <= {(a_mag_q[2] == 8'd0) && (a_mag_q[3] == 8'd0),
                    (a_mag_q[0] == 8'd0) && (a_mag_q[1] == 8'd0)};
      b_mag_q   <= a_mag_q;
      b_neg_q   <= a_neg_q;
      b_empty_q <= a_empty_q;
    end
  end

  // pair lengths
  logic [2*R2W-1:0] r2_rad [2];
  logic [TW2-1:0]   r2_tag_in;
  logic             r2_vld;
  logic [R2W-1:0]   r2_len [2];
  logic [TW2-1:0]   r2_tag;

  assign r2_rad[0] = {b_s_q[0], {(2*F){1'b0}}};
  assign r2_rad[1] = {b_s_q[1], {(2*F){1'b0}}};
  assign r2_tag_in = {b_empty_q, b_zero_q, b_neg_q,
                      b_mag_q[3], b_mag_q[2], b_mag_q[1], b_mag_q[0]};

  nmm_isqrt #(.LANES(2), .RW(R2W), .TW(TW2)) u_len2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b_vld_q),
    .rad_i   (r2_rad),
    .tag_i   (r2_tag_in),
    .valid_o (r2_vld),
    .root_o  (r2_len),
    .tag_o   (r2_tag)
  );

  // pair unit components
  logic [R2W-1:0]  d2_rem [4];
  logic [R2W-1:0]  d2_div [4];
  logic [TWD2-1:0] d2_tag_in;
  logic            d2_vld;
  logic [QW-1:0]   d2_quo [4];
  logic [TWD2-1:0] d2_tag;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      d2_rem[i] = {1'b0, r2_tag[8*i +: 8], {(F-1){1'b0}}};
      d2_div[i] = r2_len[i/2];
    end
  end
  assign d2_tag_in = r2_tag[TW2-1 -: TWD2];

  nmm_div #(.LANES(4), .DW(R2W), .QW(QW), .TW(TWD2)) u_div2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (r2_vld),
    .rem_i   (d2_rem),
    .div_i   (d2_div),
    .tag_i   (d2_tag_in),
    .valid_o (d2_vld),
    .quo_o   (d2_quo),
    .tag_o   (d2_tag)
  );

  // stage C: scale side by |top x|
  logic [QW-1:0]  u2 [4];
  logic [SQW-1:0] prod [2];
  logic [QW-1:0]  c_m_q [3];
  logic [2:0]     c_neg_q;
  logic           c_empty_q;
  logic           c_vld_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (d2_tag[4 + i/2]) begin
        u2[i] = '0;
      end else if (d2_quo[i] > ONE_Q) begin
        u2[i] = ONE_Q;
      end else begin
        u2[i] = d2_quo[i];
      end
    end
    prod[0] = {{QW{1'b0}}, u2[0]} * {{QW{1'b0}}, u2[2]};
    prod[1] = {{QW{1'b0}}, u2[1]} * {{QW{1'b0}}, u2[2]};
  end

  // stage D: squares of the direction
  logic [SQW-1:0] d_sq_q [3];
  logic [QW-1:0]  d_m_q [3];
  logic [2:0]     d_neg_q;
  logic           d_empty_q;
  logic           d_vld_q;

  // stage E: squared length of the direction
  logic [SQW-1:0] e_s3_q;
  logic           e_zero_q;
  logic [QW-1:0]  e_m_q [3];
  logic [2:0]     e_neg_q;
  logic           e_empty_q;
  logic           e_vld_q;
  logic [SQW-1:0] s3_sum;

  assign s3_sum = d_sq_q[0] + d_sq_q[1] + d_sq_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
    end else if (en) begin
      c_vld_q <= d2_vld;
      d_vld_q <= c_vld_q;
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_m_q[0]  <= prod[0][F +: QW];
      c_m_q[1]  <= prod[1][F +: QW];
      c_m_q[2]  <= u2[3];
      c_neg_q   <= {d2_tag[3], d2_tag[1], d2_tag[0]};
      c_empty_q <= d2_tag[6];
      for (int k = 0; k < 3; k++) begin
        d_sq_q[k] <= {{QW{1'b0}}, c_m_q[k]} * {{QW{1'b0}}, c_m_q[k]};
      end
      d_m_q     <= c_m_q;
      d_neg_q   <= c_neg_q;
      d_empty_q <= c_empty_q;
      e_s3_q    <= s3_sum;
      e_zero_q  <= (s3_sum == '0);
      e_m_q     <= d_m_q;
      e_neg_q   <= d_neg_q;
      e_empty_q <= d_empty_q;
    end
  end

  // direction length
  logic [2*R3W-1:0] r3_rad [1];
  logic [TW3-1:0]   r3_tag_in;
  logic             r3_vld;
  logic [R3W-1:0]   r3_len [1];
  logic [TW3-1:0]   r3_tag;

  assign r3_rad[0] = {e_s3_q, 12'd0};
  assign r3_tag_in = {e_empty_q, e_zero_q, e_neg_q, e_m_q[2], e_m_q[1], e_m_q[0]};

  nmm_isqrt #(.LANES(1), .RW(R3W), .TW(TW3)) u_len3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (e_vld_q),
    .rad_i   (r3_rad),
    .tag_i   (r3_tag_in),
    .valid_o (r3_vld),
    .root_o  (r3_len),
    .tag_o   (r3_tag)
  );

  // direction unit components
  logic [R3W-1:0]  d3_rem [3];
  logic [R3W-1:0]  d3_div [3];
  logic [TWD3-1:0] d3_tag_in;
  logic            d3_vld;
  logic [QW-1:0]   d3_quo [3];
  logic [TWD3-1:0] d3_tag;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d3_rem[k] = {1'b0, r3_tag[QW*k +: QW], 5'd0};
      d3_div[k] = r3_len[0];
    end
  end
  assign d3_tag_in = r3_tag[TW3-1 -: TWD3];

  nmm_div #(.LANES(3), .DW(R3W), .QW(QW), .TW(TWD3)) u_div3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (r3_vld),
    .rem_i   (d3_rem),
    .div_i   (d3_div),
    .tag_i   (d3_tag_in),
    .valid_o (d3_vld),
    .quo_o   (d3_quo),
    .tag_o   (d3_tag)
  );

  // output stage: encode c*128+128 clipped to the byte
  logic [QW-1:0] m3 [3];
  logic [F+1:0]  t3 [3];
  logic [8:0]    sh3 [3];
  logic [7:0]    enc [3];
  logic          out_vld_q;
  logic [7:0]    out_red_q;
  logic [7:0]    out_green_q;
  logic [7:0]    out_blue_q;
  logic [7:0]    out_alpha_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (d3_tag[3]) begin
        m3[k] = '0;
      end else if (d3_quo[k] > ONE_Q) begin
        m3[k] = ONE_Q;
      end else begin
        m3[k] = d3_quo[k];
      end
      t3[k]  = d3_tag[k] ? ONE_T - {1'b0, m3[k]} : ONE_T + {1'b0, m3[k]};
      sh3[k] = t3[k][F+1 -: 9];
      enc[k] = sh3[k][8] ? nmm_pkg::BYTE_MAX : sh3[k][7:0];
    end
  end

  assign en = !out_vld_q || pix_out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= d3_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (d3_tag[4]) begin
        out_red_q   <= 8'd0;
        out_green_q <= 8'd0;
        out_blue_q  <= 8'd0;
        out_alpha_q <= nmm_pkg::ALPHA_EMPTY;
      end else begin
        out_red_q   <= enc[0];
        out_green_q <= enc[1];
        out_blue_q  <= enc[2];
        out_alpha_q <= nmm_pkg::ALPHA_OPAQUE;
      end
    end
  end

  // ports
  assign pix_in_i.ready      = en;
  assign pix_out_o.valid     = out_vld_q;
  assign pix_out_o.out_red   = out_red_q;
  assign pix_out_o.out_green = out_green_q;
  assign pix_out_o.out_blue  = out_blue_q;
  assign pix_out_o.out_alpha = out_alpha_q;

  // checks
  logic alpha_known;
  logic empty_black;

  assign alpha_known = (out_alpha_q == nmm_pkg::ALPHA_OPAQUE) ||
                       (out_alpha_q == nmm_pkg::ALPHA_EMPTY);
  assign empty_black = (out_alpha_q != nmm_pkg::ALPHA_EMPTY) ||
                       ((out_red_q == 8'd0) && (out_green_q == 8'd0) &&
                        (out_blue_q == 8'd0));

  `NMM_ASSERT(a_alpha_code, clk_i, rst_ni, out_vld_q |-> alpha_known)
  `NMM_ASSERT(a_empty_black, clk_i, rst_ni, out_vld_q |-> empty_black)
  `NMM_ASSERT_NEXT(a_stall_keeps_front, clk_i, rst_ni, a_vld_q && !en, a_vld_q && $stable(a_mag_q[0]))

endmodule

[verif/normal_map_merge_pixel_tb.sv]
// ----------------------------------------------------------------------------
// normal_map_merge_pixel testbench
// Streams side/top pixel pair words through the merge pipeline with random
// idling on both channels and checks each merged pixel word against a
// fixed-point predictor kept in step with every accepted input word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module normal_map_merge_pixel_tb;

  localparam int unsigned FB        = nmm_pkg::FRACTION_BITS;
  localparam int unsigned LATENCY   = 4 * FB + 23;
  localparam int unsigned N_RANDOM  = 450;
  localparam int unsigned STALL_MAX = 2000;

  typedef struct packed {
    logic [7:0] side_red;
    logic [7:0] side_green;
    logic [7:0] side_alpha;
    logic [7:0] top_green;
    logic [7:0] top_blue;
  } pair_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } merged_word_t;

  // integer square root, bit by bit
  function automatic longint unsigned root_of(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // scoreboard of merged pixels still owed by the pipeline
  class merge_scoreboard;
    merged_word_t pending_q[$];
    int unsigned  n_err;
    int unsigned  n_checked;
    int unsigned  n_empty;
    int unsigned  n_zero_dir;

    // unit length pair in signed Q.FB
    function automatic void unit_pair(longint a, longint b,
                                      output longint ua, output longint ub);
      longint unsigned one, ma, mb, s, len, qa, qb;
      one = 64'd1 << FB;
      ma  = (a < 0) ? -a : a;
      mb  = (b < 0) ? -b : b;
      s   = ma * ma + mb * mb;
      if (s == 0) begin
        ua = 0;
        ub = 0;
        return;
      end
      len = root_of(s << (2 * FB));
      qa  = (ma << (2 * FB)) / len;
      qb  = (mb << (2 * FB)) / len;
      if (qa > one) qa = one;
      if (qb > one) qb = one;
      ua = (a < 0) ? -longint'(qa) : longint'(qa);
      ub = (b < 0) ? -longint'(qb) : longint'(qb);
    endfunction

    function automatic logic [7:0] encode_byte(longint c);
      longint          t;
      longint unsigned o;
      t = c + (longint'(1) << FB);
      if (t < 0) t = 0;
      o = longint'(t) >> (FB - 7);
      return (o > 255) ? nmm_pkg::BYTE_MAX : o[7:0];
    endfunction

    function automatic merged_word_t merge(pair_word_t w);
      merged_word_t    m;
      longint          sx, sy, tx, ty, v[3];
      longint unsigned one, atx, s3, len, q, mg;
      one = 64'd1 << FB;
      if (w.side_alpha == 0) begin
        m.red   = 8'd0;
        m.green = 8'd0;
        m.blue  = 8'd0;
        m.alpha = nmm_pkg::ALPHA_EMPTY;
        n_empty++;
        return m;
      end
      unit_pair(longint'(w.side_red) - 128, longint'(w.side_green) - 128, sx, sy);
      unit_pair(longint'(w.top_green) - 128, longint'(w.top_blue) - 128, tx, ty);
      atx = (tx < 0) ? -tx : tx;
      mg  = (((sx < 0) ? -sx : sx) * atx) >> FB;
      v[0] = (sx < 0) ? -longint'(mg) : longint'(mg);
      mg  = (((sy < 0) ? -sy : sy) * atx) >> FB;
      v[1] = (sy < 0) ? -longint'(mg) : longint'(mg);
      v[2] = ty;
      s3 = 0;
      foreach (v[k]) s3 += ((v[k] < 0) ? -v[k] : v[k]) * ((v[k] < 0) ? -v[k] : v[k]);
      if (s3 == 0) begin
        n_zero_dir++;
      end else begin
        len = root_of(s3 << 12);
        foreach (v[k]) begin
          q = (((v[k] < 0) ? -v[k] : v[k]) << (FB + 6)) / len;
          if (q > one) q = one;
          v[k] = (v[k] < 0) ? -longint'(q) : longint'(q);
        end
      end
      m.red   = encode_byte(v[0]);
      m.green = encode_byte(v[1]);
      m.blue  = encode_byte(v[2]);
      m.alpha = nmm_pkg::ALPHA_OPAQUE;
      return m;
    endfunction

    function void note_pair(pair_word_t w);
      pending_q.push_back(merge(w));
    endfunction

    function void check_merged(merged_word_t got);
      merged_word_t exp;
      n_checked++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected merged word %h", $time, got);
        n_err++;
        return;
      end
      exp = pending_q.pop_front();
      if (got.red !== exp.red) begin
        $display("%0t: out_red expected %0d actual %0d", $time, exp.red, got.red);
        n_err++;
      end
      if (got.green !== exp.green) begin
        $display("%0t: out_green expected %0d actual %0d", $time, exp.green, got.green);
        n_err++;
      end
      if (got.blue !== exp.blue) begin
        $display("%0t: out_blue expected %0d actual %0d", $time, exp.blue, got.blue);
        n_err++;
      end
      if (got.alpha !== exp.alpha) begin
        $display("%0t: out_alpha expected %0d actual %0d", $time, exp.alpha, got.alpha);
        n_err++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  nmm_in_if  pix_in();
  nmm_out_if pix_out();

  normal_map_merge_pixel u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_in_i  (pix_in.sink),
    .pix_out_o (pix_out.source)
  );

  merge_scoreboard sb;
  pair_word_t      stim_q[$];
  bit              quiet_phase;
  int unsigned     idle_cycles;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return nmm_pkg::BYTE_MID;
      3:       return 8'd127 + 8'($urandom_range(0, 2));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_pair(logic [7:0] r, logic [7:0] g, logic [7:0] a,
                                   logic [7:0] tg, logic [7:0] tb);
    pair_word_t w;
    w = '{r, g, a, tg, tb};
    stim_q.push_back(w);
  endfunction

  // directed corners then random words
  task automatic build_stimulus();
    pair_word_t w;
    add_pair(8'd10, 8'd200, 8'd0, 8'd40, 8'd90);       // empty pixel
    add_pair(8'd255, 8'd255, 8'd0, 8'd255, 8'd255);
    add_pair(8'd128, 8'd128, 8'd255, 8'd128, 8'd128);  // both pairs zero length
    add_pair(8'd128, 8'd128, 8'd1, 8'd200, 8'd60);     // zero side pair
    add_pair(8'd30, 8'd220, 8'd255, 8'd128, 8'd128);   // zero top pair
    add_pair(8'd30, 8'd220, 8'd255, 8'd128, 8'd20);    // top x zero
    add_pair(8'd30, 8'd220, 8'd255, 8'd20, 8'd128);    // top y zero
    add_pair(8'd0, 8'd0, 8'd255, 8'd0, 8'd0);
    add_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    add_pair(8'd0, 8'd255, 8'd128, 8'd255, 8'd0);
    add_pair(8'd255, 8'd0, 8'd127, 8'd0, 8'd255);
    add_pair(8'd0, 8'd128, 8'd255, 8'd255, 8'd128);
    add_pair(8'd128, 8'd0, 8'd255, 8'd128, 8'd255);
    add_pair(8'd255, 8'd128, 8'd255, 8'd0, 8'd128);
    add_pair(8'd128, 8'd255, 8'd255, 8'd128, 8'd0);
    add_pair(8'd129, 8'd127, 8'd2, 8'd127, 8'd129);
    add_pair(8'd170, 8'd85, 8'd64, 8'd85, 8'd170);
    add_pair(8'd224, 8'd224, 8'd255, 8'd32, 8'd224);
    repeat (N_RANDOM) begin
      w.side_red   = pick_byte();
      w.side_green = pick_byte();
      w.side_alpha = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
      w.top_green  = pick_byte();
      w.top_blue   = pick_byte();
      stim_q.push_back(w);
    end
  endtask

  // input side driver
  task automatic send_pairs();
    pair_word_t w;
    int unsigned n, total;
    total = stim_q.size();
    n = 0;
    while (stim_q.size() != 0) begin
      if (n > (total * 4) / 5) quiet_phase = 1'b1;
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        pix_in.valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
      end
      w = stim_q.pop_front();
      pix_in.valid      <= 1'b1;
      pix_in.side_red   <= w.side_red;
      pix_in.side_green <= w.side_green;
      pix_in.side_alpha <= w.side_alpha;
      pix_in.top_green  <= w.top_green;
      pix_in.top_blue   <= w.top_blue;
      do @(posedge clk_i); while (!pix_in.ready);
      @(negedge clk_i);
      n++;
    end
    pix_in.valid <= 1'b0;
  endtask

  // output side ready, stalls in bursts
  initial begin
    pix_out.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        pix_out.ready <= 1'b0;
        repeat ($urandom_range(1, 5) - 1) @(negedge clk_i);
      end else begin
        pix_out.ready <= 1'b1;
      end
    end
  end

  // sampling at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pix_in.valid && pix_in.ready) begin
        sb.note_pair(pair_word_t'({pix_in.side_red, pix_in.side_green,
                                   pix_in.side_alpha, pix_in.top_green,
                                   pix_in.top_blue}));
      end
      if (pix_out.valid && pix_out.ready) begin
        sb.check_merged(merged_word_t'({pix_out.out_red, pix_out.out_green,
                                        pix_out.out_blue, pix_out.out_alpha}));
      end
      if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog on cycles without any accepted word
  initial begin
    wait (idle_cycles >= STALL_MAX);
    $display("watchdog: no word accepted for %0d cycles", STALL_MAX);
    $display("normal_map_merge_pixel_tb failed");
    $finish;
  end

  // main sequence
  initial begin
    sb = new();
    quiet_phase = 1'b0;
    idle_cycles = 0;
    rst_ni = 1'b0;
    pix_in.valid = 1'b0;
    pix_in.side_red = '0;
    pix_in.side_green = '0;
    pix_in.side_alpha = '0;
    pix_in.top_green = '0;
    pix_in.top_blue = '0;
    build_stimulus();
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    send_pairs();
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
    $display("checked %0d merged pixels: %0d empty, %0d with zero-length direction",
             sb.n_checked, sb.n_empty, sb.n_zero_dir);
    if (sb.n_err == 0 && sb.pending_q.size() == 0) begin
      $display("normal_map_merge_pixel_tb passed");
    end else begin
      $display("%0d mismatches, %0d words outstanding", sb.n_err, sb.pending_q.size());
      $display("normal_map_merge_pixel_tb failed");
    end
    $finish;
  end

endmodule
